[design/sfsd_pkg.sv]
// Shared types, constants and helpers for the full-step stepper driver.
// No dependencies; imported by sfsd_seq and stepper_full_step_driver.
package sfsd_pkg;

	// Default width of the tick counter and its difference arithmetic
	localparam int TICK_WIDTH_DEF = 32;

	localparam int NOW_W   = 32;
	localparam int COUNT_W = 16;
	localparam int IVL_W   = 8;
	localparam int COIL_W  = 4;
	localparam int PHASE_W = 2;

	// Stream widths; the tdata widths are padded to whole bytes
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	// Command codes carried in tuser
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_MOVE = 2'd1,
		OP_STOP = 2'd2,
		OP_KEEP = 2'd3
	} op_t;

	// One command after the input register
	typedef struct packed {
		op_t                       op;
		logic [NOW_W-1:0]          now_tick;
		logic signed [COUNT_W-1:0] step_count;
		logic [IVL_W-1:0]          interval;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic              busy_res;
		logic              done_res;
		logic [COIL_W-1:0] coils;
	} res_t;

	// Coil pattern for each full-step phase (A1 A2 B1 B2)
	function automatic logic [COIL_W-1:0] phase_pattern(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] pat;
		unique case (ph)
			2'd0:    pat = 4'b1010;
			2'd1:    pat = 4'b0110;
			2'd2:    pat = 4'b0101;
			default: pat = 4'b1001;
		endcase
		return pat;
	endfunction

endpackage

[design/sfsd_seq.sv]
// Step sequencer: phase, step count, reference tick, interval and coil state.
// Computes the result of one command and updates state when it retires.
// Depends on sfsd_pkg.
module sfsd_seq
	import sfsd_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  cmd_t cmd,
	output res_t res
);

	logic [PHASE_W-1:0]        phase_q;
	logic signed [COUNT_W-1:0] rem_q;
	logic [TICK_WIDTH-1:0]     last_q;
	logic [IVL_W-1:0]          ivl_q;
	logic [COIL_W-1:0]         coil_q;

	logic [PHASE_W-1:0]        phase_d;
	logic signed [COUNT_W-1:0] rem_d;
	logic [TICK_WIDTH-1:0]     last_d;
	logic [IVL_W-1:0]          ivl_d;
	logic [COIL_W-1:0]         coil_d;
	logic                      done_d;

	logic [63:0]           now_ext;
	logic [TICK_WIDTH-1:0] now_w;
	logic [TICK_WIDTH-1:0] diff;
	logic                  take_step;

	// Tick difference modulo the counter width
	assign now_ext   = {32'd0, cmd.now_tick};
	assign now_w     = now_ext[TICK_WIDTH-1:0];
	assign diff      = now_w - last_q;
	assign take_step = (rem_q != '0) && (diff > TICK_WIDTH'(ivl_q));

	// Next state for the command in flight
	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		last_d  = last_q;
		ivl_d   = ivl_q;
		coil_d  = coil_q;
		done_d  = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				if (take_step) begin
					last_d = now_w;
					if (!rem_q[COUNT_W-1]) begin
						phase_d = phase_q + 2'd1;
						rem_d   = rem_q - 16'sd1;
					end else begin
						phase_d = phase_q - 2'd1;
						rem_d   = rem_q + 16'sd1;
					end
					coil_d = phase_pattern(phase_d);
					if (rem_d == '0) begin
						done_d = 1'b1;
						coil_d = '0;
					end
				end
			end
			OP_MOVE: begin
				rem_d  = cmd.step_count;
				ivl_d  = cmd.interval;
				last_d = now_w;
			end
			OP_STOP: begin
				coil_d = '0;
				rem_d  = '0;
			end
			default: begin
				coil_d = phase_pattern(phase_q);
			end
		endcase
	end

	assign res.coils    = coil_d;
	assign res.done_res = done_d;
	assign res.busy_res = (rem_d != '0);

	// Control state: advance on each retired command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			rem_q   <= '0;
			last_q  <= '0;
			ivl_q   <= '0;
			coil_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			last_q  <= last_d;
			ivl_q   <= ivl_d;
			coil_q  <= coil_d;
		end
	end

	// A retired stop leaves the coils off and no steps pending
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.op == OP_STOP |=> coil_q == '0 && rem_q == '0)
		else $error("stop did not clear coils and count");

	// Completion always reports coils off and not busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_res |-> res.coils == '0 && !res.busy_res)
		else $error("done with coils driven or still busy");

	// A tick with no steps left never moves the phase
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.op == OP_TICK && rem_q == '0 |=> $stable(phase_q))
		else $error("phase moved without pending steps");

	// Non-tick commands never change the phase
	a_phase_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.op != OP_TICK |=> $stable(phase_q))
		else $error("phase moved on a non-tick command");

endmodule

[design/stepper_full_step_driver.sv]
// Top level of the full-step stepper driver: input register, sequencer,
// output register with stream handshakes. Depends on sfsd_pkg and sfsd_seq.
//
//  port group  | dir | payload
//  s_axis_*    | in  | tuser: op[1:0]; tdata: now_tick, step_count, interval
//  m_axis_*    | out | tdata: coils[3:0], done_res[4], busy_res[5]
//
// One command per clock is sustained while the output is not stalled. A result
// passes through the input register and then the result register before it
// is offered.
// Reset is asynchronous and active low: phase, step count, reference tick,
// interval and coil drive all clear to zero, coils off.
// A stalled output holds its result; the input register still takes a new
// transaction when it is empty or when its command retires into the result
// register in the same cycle.
module stepper_full_step_driver
	import sfsd_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [31:0] now_tick, [47:32] step_count, [55:48] interval
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] op
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [3:0] coils, [4] done_res, [5] busy_res, [7:6] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic advance;
	res_t res;
	logic m_valid_q;
	res_t res_q;

	// Retire the staged command when the result register can take it
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1.op         <= op_t'(s_axis_tuser);
			cmd_s1.now_tick   <= s_axis_tdata[31:0];
			cmd_s1.step_count <= s_axis_tdata[47:32];
			cmd_s1.interval   <= s_axis_tdata[55:48];
		end
	end

	sfsd_seq #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, res_q};

	// Every retired command produces a result in the next cycle
	a_retire_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("retired command produced no result");

	// Input register is never overwritten while holding an unretired command
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_axis_tready)
		else $error("input register overrun");

	// A stalled result is not replaced
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |-> !advance)
		else $error("pending result overwritten");

endmodule
